// ===== rtl/sacl_pkg.sv =====
// Shared types and constants for the instruction cache.
`timescale 1ns / 1ps
package sacl_pkg;
    localparam int WAYS = 4;
    localparam int TOTAL_LINES = 256;
    localparam int LINE_BYTES = 32;
    localparam int SETS = TOTAL_LINES / WAYS;
    localparam int LINE_WORDS = LINE_BYTES / 4;
    localparam int OFF_BITS = $clog2(LINE_BYTES);
    localparam int IDX_BITS = $clog2(SETS);
    localparam int WORD_BITS = OFF_BITS - 2;
    localparam int TAG_BITS = 32 - OFF_BITS - IDX_BITS;
    localparam int WAY_BITS = $clog2(WAYS);
    localparam int RANK_BITS = $clog2(WAYS);
    localparam int FILL_WORDS = (LINE_WORDS < 8) ? LINE_WORDS : 8;

    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [IDX_BITS-1:0] set_t;
    typedef logic [WORD_BITS-1:0] woff_t;
    typedef logic [LINE_WORDS-1:0][31:0] line_t;

    typedef struct packed {
        tag_t  tag;
        set_t  set;
        woff_t word;
        line_t line;
    } req_t;
endpackage

// ===== rtl/sacl_front.sv =====
// Front end: accepts fetch words, splits the address and packs the line into a queue.
`timescale 1ns / 1ps
module sacl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [31:0]     fetch_address,
    input  logic [63:0]     line_words_01,
    input  logic [63:0]     line_words_23,
    input  logic [63:0]     line_words_45,
    input  logic [63:0]     line_words_67,
    output logic            q_valid,
    input  logic            q_pop,
    output sacl_pkg::req_t  q_data
);
    // two-entry queue
    sacl_pkg::req_t q_mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    sacl_pkg::req_t req;
    logic [255:0] flat;
    logic push;

    always_comb
    begin
        flat = {line_words_67, line_words_45, line_words_23, line_words_01};
        req.tag  = fetch_address[31 -: sacl_pkg::TAG_BITS];
        req.set  = fetch_address[sacl_pkg::OFF_BITS +: sacl_pkg::IDX_BITS];
        req.word = fetch_address[2 +: sacl_pkg::WORD_BITS];
        for (int i = 0; i < sacl_pkg::LINE_WORDS; i++)
        begin
            req.line[i] = (i < sacl_pkg::FILL_WORDS) ? flat[i*32 +: 32] : 32'd0;
        end
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// ===== rtl/sacl_back.sv =====
// Back end: tag lookup, LRU update, line fill and the output register.
`timescale 1ns / 1ps
module sacl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_pop,
    input  sacl_pkg::req_t  q_data,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [31:0]     read_word,
    output logic            was_hit
);
    localparam logic [1:0] ST_LOOK = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    localparam int LN_BITS = sacl_pkg::IDX_BITS + sacl_pkg::WAY_BITS;

    typedef logic [sacl_pkg::WAYS-1:0][sacl_pkg::TAG_BITS-1:0]  set_tags_t;
    typedef logic [sacl_pkg::WAYS-1:0][sacl_pkg::RANK_BITS-1:0] set_ranks_t;

    logic [1:0] state_reg, state_next;

    // one tag and rank entry per set, one data entry per line; valid bits in flops
    set_tags_t       tag_mem [sacl_pkg::SETS];
    set_ranks_t      rank_mem [sacl_pkg::SETS];
    sacl_pkg::line_t data_mem [sacl_pkg::TOTAL_LINES];
    logic [sacl_pkg::TOTAL_LINES-1:0] valid_reg;

    set_tags_t   tag_rd_reg;
    set_ranks_t  rank_rd_reg;
    logic [31:0] word_reg;
    logic        hit_reg;

    logic [sacl_pkg::WAYS-1:0] hit_vec, vld_vec;
    logic any_hit, found, set_live;
    logic [sacl_pkg::WAY_BITS-1:0] hit_way, vic_way, sel_way;
    logic [sacl_pkg::RANK_BITS-1:0] sel_rank;
    logic [LN_BITS-1:0] sel_ln;
    set_ranks_t rank_cur, rank_new;
    set_tags_t  tags_new;

    function automatic logic [LN_BITS-1:0] ln_of(sacl_pkg::set_t s,
                                                  logic [sacl_pkg::WAY_BITS-1:0] w);
        return {s, w};
    endfunction

    always_comb
    begin
        for (int i = 0; i < sacl_pkg::WAYS; i++)
        begin
            vld_vec[i] = valid_reg[ln_of(q_data.set, i[sacl_pkg::WAY_BITS-1:0])];
        end
        // a set with no valid way reads its ranks as zero
        set_live = |vld_vec;
        rank_cur = set_live ? rank_rd_reg : '0;
        any_hit = 1'b0;
        hit_way = '0;
        for (int i = 0; i < sacl_pkg::WAYS; i++)
        begin
            hit_vec[i] = vld_vec[i] && (tag_rd_reg[i] == q_data.tag);
        end
        for (int i = sacl_pkg::WAYS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                any_hit = 1'b1;
                hit_way = i[sacl_pkg::WAY_BITS-1:0];
            end
        end
        found = 1'b0;
        vic_way = '0;
        for (int i = 0; i < sacl_pkg::WAYS; i++)
        begin
            if (!found && !vld_vec[i])
            begin
                found = 1'b1;
                vic_way = i[sacl_pkg::WAY_BITS-1:0];
            end
        end
        for (int i = 0; i < sacl_pkg::WAYS; i++)
        begin
            if (!found && rank_cur[i] == '0)
            begin
                found = 1'b1;
                vic_way = i[sacl_pkg::WAY_BITS-1:0];
            end
        end
        sel_way  = any_hit ? hit_way : vic_way;
        sel_ln   = ln_of(q_data.set, sel_way);
        sel_rank = rank_cur[sel_way];
        // promote: higher ranks drop, chosen way goes to top
        for (int i = 0; i < sacl_pkg::WAYS; i++)
        begin
            rank_new[i] = (rank_cur[i] > sel_rank) ? rank_cur[i] - 1'b1 : rank_cur[i];
        end
        rank_new[sel_way] = sacl_pkg::RANK_BITS'(sacl_pkg::WAYS - 1);
        tags_new = tag_rd_reg;
        tags_new[sel_way] = q_data.tag;
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        case (state_reg)
            ST_LOOK: if (q_valid) state_next = ST_READ;
            ST_READ: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    q_pop = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            default: state_next = ST_LOOK;
        endcase
    end

    assign out_valid = (state_reg == ST_OUT);
    assign read_word = word_reg;
    assign was_hit   = hit_reg;

    // set read in the look step, set and line write in the update step
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOK)
        begin
            tag_rd_reg  <= tag_mem[q_data.set];
            rank_rd_reg <= rank_mem[q_data.set];
        end
        if (state_reg == ST_READ)
        begin
            hit_reg <= any_hit;
            tag_mem[q_data.set]  <= tags_new;
            rank_mem[q_data.set] <= rank_new;
            if (!any_hit)
            begin
                data_mem[sel_ln] <= q_data.line;
                word_reg <= q_data.line[q_data.word];
            end
            else
            begin
                word_reg <= data_mem[sel_ln][q_data.word];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOOK;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_READ)
            begin
                valid_reg[sel_ln] <= 1'b1;
            end
        end
    end
endmodule

// ===== rtl/set_assoc_icache_lru.sv =====
// Top level of the four-way LRU instruction cache.
// Each word goes from the queue through the look, update and present steps of the back end.
// The back end finishes one word before it takes the next; a stalled result is held.
// A two-word queue lets the input run ahead while the back end is busy.
// Reset clears valid bits at once; ranks of a set read as zero until its first fill.
`timescale 1ns / 1ps
module set_assoc_icache_lru (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] fetch_address,
    input  logic [63:0] line_words_01,
    input  logic [63:0] line_words_23,
    input  logic [63:0] line_words_45,
    input  logic [63:0] line_words_67,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_word,
    output logic        was_hit
);
    logic q_valid, q_pop;
    sacl_pkg::req_t q_data;

    sacl_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .fetch_address(fetch_address), .line_words_01(line_words_01),
        .line_words_23(line_words_23), .line_words_45(line_words_45),
        .line_words_67(line_words_67), .q_valid(q_valid), .q_pop(q_pop),
        .q_data(q_data)
    );

    sacl_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
        .out_valid(out_valid), .out_stall(out_stall), .read_word(read_word),
        .was_hit(was_hit)
    );

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_word) && $stable(was_hit))
        else $error("result changed while stalled");
    a_pop_on_delivery: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> out_valid && !out_stall) else $error("queue popped without delivery");
endmodule
